>>> src/rlmtf_pkg.sv
// Package for the move-to-front recent list: sizes, operation codes and
// the control struct broadcast to every list cell. No dependencies.
package rlmtf_pkg;

   localparam int CAPACITY     = 7;
   localparam int ID_BITS      = 16;
   localparam int PAYLOAD_BITS = 32;
   localparam int POS_BITS     = 3;
   localparam int OCC_BITS     = 3;
   localparam int CNT_BITS     = $clog2(CAPACITY + 1);

   typedef enum logic [0:0] {
      OP_PUSH = 1'b0,
      OP_READ = 1'b1
   } op_type;

   typedef struct packed {
      logic               push;
      logic [ID_BITS-1:0] id;
   } cell_ctl_type;

endpackage

>>> src/rlmtf_cell.sv
// One position of the recent list: holds an id and payload, compares the
// id against a push and takes its neighbour's entry on a shift.
// Depends on rlmtf_pkg.
module rlmtf_cell (
   input  logic                                 clock,
   input  rlmtf_pkg::cell_ctl_type              ctl,
   input  logic                                 live,
   input  logic [rlmtf_pkg::ID_BITS-1:0]        prev_id,
   input  logic [rlmtf_pkg::PAYLOAD_BITS-1:0]   prev_payload,
   input  logic                                 found_in,
   output logic                                 found_out,
   output logic [rlmtf_pkg::ID_BITS-1:0]        id,
   output logic [rlmtf_pkg::PAYLOAD_BITS-1:0]   payload
);
   import rlmtf_pkg::*;

   logic [ID_BITS-1:0]      id_ff;
   logic [PAYLOAD_BITS-1:0] payload_ff;
   logic                    shift;
   logic                    match;

   // every cell up to and including the first hit moves back by one
   assign shift     = ctl.push && !found_in;
   assign match     = live && (id_ff == ctl.id);
   assign found_out = found_in | match;

   always_ff @(posedge clock) begin
      if (shift) begin
         id_ff      <= prev_id;
         payload_ff <= prev_payload;
      end
   end

   assign id      = id_ff;
   assign payload = payload_ff;

endmodule

>>> src/recent_list_move_to_front_top.sv
// Top level of the move-to-front recent list: request decode, fill count,
// result register and the row of rlmtf_cell instances.
// Depends on rlmtf_pkg and rlmtf_cell.
//
//  channel   ports                                  handshake
//  request   req_operation/entry_id/payload/position start, accepted when busy low
//  response  rsp_hit ... rsp_read_payload           rsp_valid strobe, one cycle
//
// For each request the id is compared in every cell at once, the
// first-hit search ripples down the cell row, and the shift lands at the edge
// that accepts the request. The response is shown in the following cycle.
// busy stays low, so a request may be given in every cycle.
// Synchronous reset empties the list; the receiver cannot stall responses.
module recent_list_move_to_front_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  rlmtf_pkg::op_type                    req_operation,
   input  logic [rlmtf_pkg::ID_BITS-1:0]        req_entry_id,
   input  logic [rlmtf_pkg::PAYLOAD_BITS-1:0]   req_entry_payload,
   input  logic [rlmtf_pkg::POS_BITS-1:0]       req_read_position,
   output logic                                 rsp_valid,
   output logic                                 rsp_hit,
   output logic [rlmtf_pkg::POS_BITS-1:0]       rsp_hit_position,
   output logic                                 rsp_evicted,
   output logic [rlmtf_pkg::ID_BITS-1:0]        rsp_evicted_id,
   output logic [rlmtf_pkg::PAYLOAD_BITS-1:0]   rsp_evicted_payload,
   output logic [rlmtf_pkg::OCC_BITS-1:0]       rsp_occupancy,
   output logic                                 rsp_read_valid,
   output logic [rlmtf_pkg::ID_BITS-1:0]        rsp_read_id,
   output logic [rlmtf_pkg::PAYLOAD_BITS-1:0]   rsp_read_payload
);
   import rlmtf_pkg::*;

   logic                    accept;
   logic                    push;
   logic                    rd;
   cell_ctl_type            ctl;
   logic [CNT_BITS-1:0]     fill_ff, fill_in;
   logic                    full;
   logic                    found_any;
   logic [CAPACITY-1:0]     live;
   logic [CAPACITY:0]       found_chain;
   logic [ID_BITS-1:0]      cell_id [CAPACITY+1];
   logic [PAYLOAD_BITS-1:0] cell_pl [CAPACITY+1];

   logic [POS_BITS-1:0]     hit_pos;
   logic                    rd_ok;
   logic [ID_BITS-1:0]      rd_id;
   logic [PAYLOAD_BITS-1:0] rd_pl;

   logic                    rsp_valid_ff;
   logic                    hit_ff, evicted_ff, read_valid_ff;
   logic [POS_BITS-1:0]     hit_pos_ff;
   logic [ID_BITS-1:0]      ev_id_ff, rd_id_ff;
   logic [PAYLOAD_BITS-1:0] ev_pl_ff, rd_pl_ff;
   logic [OCC_BITS-1:0]     occ_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign push   = accept && (req_operation == OP_PUSH);
   assign rd     = accept && (req_operation == OP_READ);

   assign ctl.push = push;
   assign ctl.id   = req_entry_id;

   // cell 0 takes the pushed entry
   assign cell_id[0]     = req_entry_id;
   assign cell_pl[0]     = req_entry_payload;
   assign found_chain[0] = 1'b0;

   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      assign live[k] = (CNT_BITS'(k) < fill_ff);
      rlmtf_cell u_cell (
         .clock        (clock),
         .ctl          (ctl),
         .live         (live[k]),
         .prev_id      (cell_id[k]),
         .prev_payload (cell_pl[k]),
         .found_in     (found_chain[k]),
         .found_out    (found_chain[k+1]),
         .id           (cell_id[k+1]),
         .payload      (cell_pl[k+1])
      );
   end

   assign found_any = found_chain[CAPACITY];
   assign full      = (fill_ff == CNT_BITS'(CAPACITY));

   always_comb begin
      fill_in = fill_ff;
      if (push && !found_any && !full) begin
         fill_in = fill_ff + CNT_BITS'(1);
      end
   end

   // encode the first hit and select the read entry
   always_comb begin
      hit_pos = '0;
      rd_id   = '0;
      rd_pl   = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         if (found_chain[k+1] && !found_chain[k]) begin
            hit_pos = hit_pos | POS_BITS'(k);
         end
         if (req_read_position == POS_BITS'(k)) begin
            rd_id = cell_id[k+1];
            rd_pl = cell_pl[k+1];
         end
      end
   end

   assign rd_ok = (CNT_BITS + POS_BITS)'(req_read_position)
                  < (CNT_BITS + POS_BITS)'(fill_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hit_ff        <= push && found_any;
         hit_pos_ff    <= (push && found_any) ? hit_pos : '0;
         evicted_ff    <= push && !found_any && full;
         ev_id_ff      <= (push && !found_any && full) ? cell_id[CAPACITY] : '0;
         ev_pl_ff      <= (push && !found_any && full) ? cell_pl[CAPACITY] : '0;
         occ_ff        <= OCC_BITS'(fill_in);
         read_valid_ff <= rd && rd_ok;
         rd_id_ff      <= (rd && rd_ok) ? rd_id : '0;
         rd_pl_ff      <= (rd && rd_ok) ? rd_pl : '0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_hit             = hit_ff;
   assign rsp_hit_position    = hit_pos_ff;
   assign rsp_evicted         = evicted_ff;
   assign rsp_evicted_id      = ev_id_ff;
   assign rsp_evicted_payload = ev_pl_ff;
   assign rsp_occupancy       = occ_ff;
   assign rsp_read_valid      = read_valid_ff;
   assign rsp_read_id         = rd_id_ff;
   assign rsp_read_payload    = rd_pl_ff;

   a_rsp_follows_req : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("request accepted without a response");

   a_hit_evict_excl : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_evicted))
      else $error("hit and eviction in one response");

   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_BITS'(CAPACITY))
      else $error("fill count beyond capacity");

   a_fill_monotonic : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> fill_ff >= $past(fill_ff))
      else $error("fill count dropped without reset");

endmodule
